### rtl/psrp_pkg.sv
// Shared types and constants of the particle sensor reply parser.
// No dependencies; used by psrp_step, the top level and the checker.
package psrp_pkg;

  localparam int unsigned AUTO_FRAME_BYTES = 32;
  localparam int unsigned POS_W            = 6;

  localparam logic [31:0] HEADER_RESET = 32'h424D_001C;
  localparam logic [7:0]  NACK_BYTE    = 8'h96;
  localparam logic [7:0]  ACK_BYTE     = 8'hA5;
  localparam logic [15:0] PM_RESET     = 16'd10;

  localparam logic [POS_W-1:0] AUTO_LAST  = POS_W'(AUTO_FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] AUTO_SUM_END = POS_W'(AUTO_FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] QUERY_LAST = POS_W'(7);
  localparam logic [POS_W-1:0] COEF_LAST  = POS_W'(4);
  localparam logic [POS_W-1:0] ACK_LAST   = POS_W'(1);

  // config register indexes
  localparam logic CFG_EXPECTED_REPLY = 1'b0;
  localparam logic CFG_AUTO_HEADER    = 1'b1;

  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_COEF  = 2'd2,
    MODE_ACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_NO_ACK = 2'd2
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [15:0]      running_sum;
    logic             header_ok;
    logic [7:0]       held_high_byte;
    logic [15:0]      pending_pm10;
    logic [15:0]      pending_pm2_5;
    logic [7:0]       pending_coefficient;
    logic [7:0]       first_reply_byte;
    logic [15:0]      stored_pm10;
    logic [15:0]      stored_pm2_5;
  } parse_state_t;

  typedef struct packed {
    logic        last;
    status_t     status;
    logic [15:0] pm10;
    logic [15:0] pm2_5;
    logic [7:0]  coefficient;
    logic        coefficient_valid;
  } step_result_t;

endpackage

### rtl/particle_sensor_reply_parser.sv
// Top level of the particle sensor reply parser: config registers, parser
// state, result register. Depends on psrp_pkg and psrp_step.
//
// Usage:
//   Input channel (in_valid/in_ready): one received UART byte per item,
//   rx_byte, with frame_start set on the first byte of a reply to restart
//   the byte count, sum and header check. Without frame_start a reply still
//   ends after its nominal length and the next byte opens a new one.
//   Output channel (out_valid/out_ready): one item per completed reply, on
//   its final byte: reply_status, the kept PM10/PM2.5 readings and, for a
//   coefficient reply that passed its check, the coefficient.
//   Config port: cfg_write with cfg_index 0 selects the expected reply
//   (auto 32 bytes, query 8, coefficient 5, ack 2), index 1 loads the four
//   auto-frame header bytes, first byte in bits 31..24. Write only while idle.
// Timing:
//   Each byte is parsed in the cycle it is accepted; a reply result shows on
//   the output in the cycle after its final byte is accepted. One byte per
//   cycle unless a result is stalled, set by the single state-update step.
// Reset (rst, synchronous): expected_reply = auto frame, header 0x424D001C,
//   readings 10, output empty.
// Stall: the result register holds while out_ready is low; in_ready is low
//   whenever a result is held and out_ready is low, and returns with it.
module particle_sensor_reply_parser (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  // reply result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  reply_status,
  output logic [15:0] pm10_value,
  output logic [15:0] pm2_5_value,
  output logic [7:0]  coefficient,
  output logic        coefficient_valid
);

  psrp_pkg::mode_t        expected_reply;
  logic [31:0]            auto_header;
  psrp_pkg::parse_state_t st;
  psrp_pkg::parse_state_t st_next;
  psrp_pkg::step_result_t res;
  logic                   in_take;
  logic                   out_free;

  psrp_step u_step (
    .st          (st),
    .mode        (expected_reply),
    .auto_header (auto_header),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .st_next     (st_next),
    .res         (res)
  );

  // Result slot is free if empty or being drained this cycle; input waits
  // on the slot for every byte.
  assign out_free = !out_valid || out_ready;
  assign in_ready = out_free;
  assign in_take  = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_reply <= psrp_pkg::MODE_AUTO;
      auto_header    <= psrp_pkg::HEADER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        psrp_pkg::CFG_EXPECTED_REPLY: expected_reply <= psrp_pkg::mode_t'(cfg_data[1:0]);
        psrp_pkg::CFG_AUTO_HEADER:    auto_header    <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{header_ok:    1'b1,
              stored_pm10:  psrp_pkg::PM_RESET,
              stored_pm2_5: psrp_pkg::PM_RESET,
              default:      '0};
    end else if (in_take) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && res.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res.last) begin
      reply_status      <= 2'(res.status);
      pm10_value        <= res.pm10;
      pm2_5_value       <= res.pm2_5;
      coefficient       <= res.coefficient;
      coefficient_valid <= res.coefficient_valid;
    end
  end

endmodule

### rtl/psrp_step.sv
// Per-byte parse step: next parser state and the reply result for one byte.
// Depends on psrp_pkg.
module psrp_step (
  input  psrp_pkg::parse_state_t st,
  input  psrp_pkg::mode_t        mode,
  input  logic [31:0]            auto_header,
  input  logic [7:0]             rx_byte,
  input  logic                   frame_start,
  output psrp_pkg::parse_state_t st_next,
  output psrp_pkg::step_result_t res
);

  logic [psrp_pkg::POS_W-1:0] pos;
  logic [psrp_pkg::POS_W-1:0] last_pos;
  logic [15:0]                sum_base;
  logic                       hok_base;
  logic                       last;
  logic [7:0]                 want;
  logic [15:0]                word;
  logic [7:0]                 neg_sum;

  assign pos      = frame_start ? '0 : st.byte_position;
  assign sum_base = frame_start ? 16'd0 : st.running_sum;
  assign hok_base = frame_start ? 1'b1 : st.header_ok;
  assign word     = {st.held_high_byte, rx_byte};
  assign neg_sum  = 8'(16'd0 - sum_base);

  always_comb begin
    case (mode)
      psrp_pkg::MODE_AUTO:  last_pos = psrp_pkg::AUTO_LAST;
      psrp_pkg::MODE_QUERY: last_pos = psrp_pkg::QUERY_LAST;
      psrp_pkg::MODE_COEF:  last_pos = psrp_pkg::COEF_LAST;
      default:              last_pos = psrp_pkg::ACK_LAST;
    endcase
  end

  assign last = (pos >= last_pos);

  // header byte 0 sits in the top byte
  always_comb begin
    case (pos[1:0])
      2'd0:    want = auto_header[31:24];
      2'd1:    want = auto_header[23:16];
      2'd2:    want = auto_header[15:8];
      default: want = auto_header[7:0];
    endcase
  end

  always_comb begin
    st_next                = st;
    st_next.running_sum    = sum_base;
    st_next.header_ok      = hok_base;
    st_next.held_high_byte = rx_byte;
    st_next.byte_position  = last ? '0 : pos + 1'b1;
    if (pos == '0) begin
      st_next.first_reply_byte = rx_byte;
    end

    res.last              = last;
    res.status            = psrp_pkg::ST_OK;
    res.coefficient       = 8'd0;
    res.coefficient_valid = 1'b0;

    case (mode)
      psrp_pkg::MODE_AUTO: begin
        if (pos < psrp_pkg::POS_W'(4) && rx_byte != want) begin
          st_next.header_ok = 1'b0;
        end
        if (pos == psrp_pkg::POS_W'(7)) begin
          st_next.pending_pm2_5 = word;
        end
        if (pos == psrp_pkg::POS_W'(9)) begin
          st_next.pending_pm10 = word;
        end
        if (pos < psrp_pkg::AUTO_SUM_END) begin
          st_next.running_sum = sum_base + 16'(rx_byte);
        end
        if (last) begin
          if (st_next.header_ok && st_next.running_sum == word) begin
            st_next.stored_pm10  = st_next.pending_pm10;
            st_next.stored_pm2_5 = st_next.pending_pm2_5;
          end else begin
            res.status = psrp_pkg::ST_BAD;
          end
        end
      end
      psrp_pkg::MODE_QUERY, psrp_pkg::MODE_COEF: begin
        if (mode == psrp_pkg::MODE_QUERY) begin
          if (pos == psrp_pkg::POS_W'(4)) begin
            st_next.pending_pm2_5 = word;
          end
          if (pos == psrp_pkg::POS_W'(6)) begin
            st_next.pending_pm10 = word;
          end
        end else if (pos == psrp_pkg::POS_W'(3)) begin
          st_next.pending_coefficient = rx_byte;
        end
        if (last) begin
          if (neg_sum == rx_byte) begin
            if (mode == psrp_pkg::MODE_QUERY) begin
              st_next.stored_pm10  = st_next.pending_pm10;
              st_next.stored_pm2_5 = st_next.pending_pm2_5;
            end else begin
              res.coefficient       = st_next.pending_coefficient;
              res.coefficient_valid = 1'b1;
            end
          end else begin
            res.status = psrp_pkg::ST_BAD;
          end
        end else begin
          st_next.running_sum = sum_base + 16'(rx_byte);
        end
      end
      default: begin
        if (st_next.first_reply_byte == psrp_pkg::NACK_BYTE) begin
          res.status = psrp_pkg::ST_BAD;
        end else if (st_next.first_reply_byte == psrp_pkg::ACK_BYTE) begin
          res.status = psrp_pkg::ST_OK;
        end else begin
          res.status = psrp_pkg::ST_NO_ACK;
        end
      end
    endcase

    res.pm10  = st_next.stored_pm10;
    res.pm2_5 = st_next.stored_pm2_5;
  end

endmodule

### rtl/psrp_checker.sv
// Port-level checks for the particle sensor reply parser, bound to the top.
// Depends on psrp_pkg.
module psrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  reply_status,
  input logic [15:0] pm10_value,
  input logic [7:0]  coefficient,
  input logic        coefficient_valid
);

  // an empty result slot never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reply_status)
      && $stable(pm10_value) && $stable(coefficient))
    else $error("stalled result changed");

  // a coefficient is only reported with a passing status
  a_coef_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && coefficient_valid |-> reply_status == 2'(psrp_pkg::ST_OK))
    else $error("coefficient valid on failing reply");

  // unchecked coefficient reads as zero
  a_coef_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !coefficient_valid |-> coefficient == 8'd0)
    else $error("coefficient nonzero without valid");

endmodule

bind particle_sensor_reply_parser psrp_checker u_psrp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .reply_status      (reply_status),
  .pm10_value        (pm10_value),
  .coefficient       (coefficient),
  .coefficient_valid (coefficient_valid)
);

### tb/reply_parser_checker.sv
// Checker for the particle sensor reply parser: watches the config port and both item
// channels, predicts each reply result from the received bytes and compares it.
// Depends on psrp_pkg for the reply modes, status codes, bytes and reply lengths.
module reply_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  reply_status,
  input  logic [15:0] pm10_value,
  input  logic [15:0] pm2_5_value,
  input  logic [7:0]  coefficient,
  input  logic        coefficient_valid,
  output int          mismatches,
  output int          waiting,
  output int          replies_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    psrp_pkg::status_t status;
    logic [15:0]       pm10;
    logic [15:0]       pm2_5;
    logic [7:0]        coef;
    logic              coef_ok;
  } reply_t;

  reply_t      expected_replies[$];
  reply_t      want;
  int          miss;
  int          seen;

  // predictor copy of registers and parser state
  psrp_pkg::mode_t reply_mode;
  logic [31:0] header_word;
  logic [5:0]  byte_pos;
  logic [15:0] run_sum;
  logic        hdr_ok;
  logic [7:0]  prev_byte;
  logic [7:0]  lead_byte;
  logic [15:0] pm10_pend;
  logic [15:0] pm25_pend;
  logic [7:0]  coef_pend;
  logic [15:0] pm10_kept;
  logic [15:0] pm25_kept;

  function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t %s: expected %0h, got %0h", $time, what, want_v, got_v);
      miss++;
    end
  endfunction

  // one received byte through the parser; pushes a reply on the final byte
  task automatic parse_byte(input logic [7:0] b, input logic restart);
    logic [5:0] pos;
    logic [5:0] final_pos;
    logic       last;
    logic [7:0] header_byte;
    logic [7:0] neg_sum;
    reply_t     r;
    case (reply_mode)
      psrp_pkg::MODE_AUTO:  final_pos = psrp_pkg::AUTO_LAST;
      psrp_pkg::MODE_QUERY: final_pos = psrp_pkg::QUERY_LAST;
      psrp_pkg::MODE_COEF:  final_pos = psrp_pkg::COEF_LAST;
      default:              final_pos = psrp_pkg::ACK_LAST;
    endcase
    pos = restart ? '0 : byte_pos;
    if (restart) begin
      run_sum = '0;
      hdr_ok  = 1'b1;
    end
    // a mode switch mid-reply can leave pos past the new final byte
    last = (pos >= final_pos);
    if (pos == 0) lead_byte = b;
    r.status  = psrp_pkg::ST_OK;
    r.coef    = '0;
    r.coef_ok = 1'b0;
    case (reply_mode)
      psrp_pkg::MODE_AUTO: begin
        if (pos < 4) begin
          header_byte = 8'(header_word >> (8 * (3 - pos)));
          if (b != header_byte) hdr_ok = 1'b0;
        end
        if (pos == 7) pm25_pend = {prev_byte, b};
        if (pos == 9) pm10_pend = {prev_byte, b};
        if (pos < psrp_pkg::AUTO_SUM_END) run_sum = run_sum + b;
        if (last) begin
          if (hdr_ok && run_sum == {prev_byte, b}) begin
            pm10_kept = pm10_pend;
            pm25_kept = pm25_pend;
          end else begin
            r.status = psrp_pkg::ST_BAD;
          end
        end
      end
      psrp_pkg::MODE_QUERY, psrp_pkg::MODE_COEF: begin
        if (reply_mode == psrp_pkg::MODE_QUERY) begin
          if (pos == 4) pm25_pend = {prev_byte, b};
          if (pos == 6) pm10_pend = {prev_byte, b};
        end else if (pos == 3) begin
          coef_pend = b;
        end
        if (last) begin
          neg_sum = 8'd0 - run_sum[7:0];
          if (neg_sum == b) begin
            if (reply_mode == psrp_pkg::MODE_QUERY) begin
              pm10_kept = pm10_pend;
              pm25_kept = pm25_pend;
            end else begin
              r.coef    = coef_pend;
              r.coef_ok = 1'b1;
            end
          end else begin
            r.status = psrp_pkg::ST_BAD;
          end
        end else begin
          run_sum = run_sum + b;
        end
      end
      default: begin
        if (last) begin
          if (lead_byte == psrp_pkg::NACK_BYTE)     r.status = psrp_pkg::ST_BAD;
          else if (lead_byte == psrp_pkg::ACK_BYTE) r.status = psrp_pkg::ST_OK;
          else                                      r.status = psrp_pkg::ST_NO_ACK;
        end
      end
    endcase
    prev_byte = b;
    if (last) begin
      byte_pos = '0;
      r.pm10   = pm10_kept;
      r.pm2_5  = pm25_kept;
      expected_replies.push_back(r);
    end else begin
      byte_pos = pos + 6'd1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_replies.delete();
      miss        = 0;
      seen        = 0;
      reply_mode  = psrp_pkg::MODE_AUTO;
      header_word = psrp_pkg::HEADER_RESET;
      byte_pos    = '0;
      run_sum     = '0;
      hdr_ok      = 1'b1;
      prev_byte   = '0;
      lead_byte   = '0;
      pm10_pend   = '0;
      pm25_pend   = '0;
      coef_pend   = '0;
      pm10_kept   = psrp_pkg::PM_RESET;
      pm25_kept   = psrp_pkg::PM_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t reply with none expected: status %0d pm10 %h pm2.5 %h coef %h/%b",
                   $time, reply_status, pm10_value, pm2_5_value, coefficient,
                   coefficient_valid);
          miss++;
        end else begin
          want = expected_replies.pop_front();
          check_field("reply_status", want.status, reply_status);
          check_field("pm10_value", want.pm10, pm10_value);
          check_field("pm2_5_value", want.pm2_5, pm2_5_value);
          check_field("coefficient", want.coef, coefficient);
          check_field("coefficient_valid", want.coef_ok, coefficient_valid);
          seen++;
        end
      end
      // the byte taken at this edge still sees the old registers
      if (in_valid && in_ready) parse_byte(rx_byte, frame_start);
      if (cfg_write) begin
        if (cfg_index == psrp_pkg::CFG_EXPECTED_REPLY) begin
          reply_mode = psrp_pkg::mode_t'(cfg_data[1:0]);
        end else begin
          header_word = cfg_data;
        end
      end
    end
    mismatches      <= miss;
    waiting         <= expected_replies.size();
    replies_checked <= seen;
  end

endmodule

### tb/testbench.sv
// Top of the particle sensor reply parser testbench: clock, reset, config writes,
// byte stimulus, output stalls, watchdog and verdict. Depends on psrp_pkg,
// reply_parser_checker and the parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 800;  // received bytes before the random part stops
  localparam int STALL_LIMIT   = 1000; // cycles without any item moving

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  reply_status;
  logic [15:0] pm10_value;
  logic [15:0] pm2_5_value;
  logic [7:0]  coefficient;
  logic        coefficient_valid;

  int          mismatches;
  int          waiting;
  int          replies_checked;

  // stimulus side copy of the registers, used to build well-formed replies
  psrp_pkg::mode_t cur_mode;
  logic [31:0] cur_header;
  logic [7:0]  frame_buf [psrp_pkg::AUTO_FRAME_BYTES];
  logic        calm;          // no idling on either side while set
  int          bytes_sent;
  int          phase;
  int          stall_cycles;

  particle_sensor_reply_parser u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .reply_status      (reply_status),
    .pm10_value        (pm10_value),
    .pm2_5_value       (pm2_5_value),
    .coefficient       (coefficient),
    .coefficient_valid (coefficient_valid)
  );

  reply_parser_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .reply_status      (reply_status),
    .pm10_value        (pm10_value),
    .pm2_5_value       (pm2_5_value),
    .coefficient       (coefficient),
    .coefficient_valid (coefficient_valid),
    .mismatches        (mismatches),
    .waiting           (waiting),
    .replies_checked   (replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: drops ready at random with an 11 percent chance, never while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 11);
  end

  // Watchdog: any cycle where neither channel moves an item counts toward the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles at %0t", STALL_LIMIT, $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Bytes are mostly random, with the two extremes showing up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Fills frame_buf with a reply that passes its checks for the current mode
  // (assuming it opens with frame_start) and returns its length.
  function automatic int build_frame();
    logic [15:0] sum;
    int          n;
    int          i;
    sum = '0;
    case (cur_mode)
      psrp_pkg::MODE_AUTO:  n = psrp_pkg::AUTO_FRAME_BYTES;
      psrp_pkg::MODE_QUERY: n = int'(psrp_pkg::QUERY_LAST) + 1;
      psrp_pkg::MODE_COEF:  n = int'(psrp_pkg::COEF_LAST) + 1;
      default:              n = int'(psrp_pkg::ACK_LAST) + 1;
    endcase
    for (i = 0; i < n; i++) frame_buf[i] = pick_byte();
    case (cur_mode)
      psrp_pkg::MODE_AUTO: begin
        // header first byte in the top bits, big-endian sum of bytes 0..29 at the end
        for (i = 0; i < 4; i++) frame_buf[i] = 8'(cur_header >> (8 * (3 - i)));
        for (i = 0; i < n - 2; i++) sum = sum + frame_buf[i];
        frame_buf[n-2] = sum[15:8];
        frame_buf[n-1] = sum[7:0];
      end
      psrp_pkg::MODE_QUERY, psrp_pkg::MODE_COEF: begin
        // check byte is the negated low byte of the sum of everything before it
        for (i = 0; i < n - 1; i++) sum = sum + frame_buf[i];
        frame_buf[n-1] = 8'd0 - sum[7:0];
      end
      default: begin
        case ($urandom_range(3))
          0, 1:    frame_buf[0] = psrp_pkg::ACK_BYTE;
          2:       frame_buf[0] = psrp_pkg::NACK_BYTE;
          default: ;  // leave the random first byte: unrecognised reply
        endcase
      end
    endcase
    return n;
  endfunction

  // Offers one byte and returns at the edge that accepts it. Valid is left high so
  // back-to-back items need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first count bytes of frame_buf; restart sets frame_start on byte 0.
  task automatic send_frame(input int count, input logic restart);
    int i;
    for (i = 0; i < count; i++) send_byte(frame_buf[i], restart && (i == 0));
  endtask

  // Drains the block: valid low, every expected reply taken, then a few spare
  // cycles since the last bytes may still be inside a reply with no result.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == psrp_pkg::CFG_EXPECTED_REPLY) cur_mode = psrp_pkg::mode_t'(value[1:0]);
    else                                     cur_header = value;
  endtask

  initial begin
    int          n;
    int          nreplies;
    int          kind;
    int          p;
    int          i;
    logic [31:0] hdr;
    logic [1:0]  m;

    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= psrp_pkg::CFG_EXPECTED_REPLY;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    rx_byte     <= '0;
    frame_start <= 1'b0;
    out_ready   <= 1'b0;
    calm        <= 1'b0;
    cur_mode    = psrp_pkg::MODE_AUTO;
    cur_header  = psrp_pkg::HEADER_RESET;
    bytes_sent  = 0;
    phase       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // ack replies: ack, nack, then an unrecognised first byte on a reply that
    // opens without frame_start (boundary after the previous final byte)
    write_reg(psrp_pkg::CFG_EXPECTED_REPLY, 32'(psrp_pkg::MODE_ACK));
    send_byte(psrp_pkg::ACK_BYTE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(psrp_pkg::NACK_BYTE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(psrp_pkg::ACK_BYTE, 1'b0);
    settle_block();
    // coefficient reply with the largest coefficient, check 0xFE
    write_reg(psrp_pkg::CFG_EXPECTED_REPLY, 32'(psrp_pkg::MODE_COEF));
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    settle_block();
    // query reply carrying the largest readings, check 0x07
    write_reg(psrp_pkg::CFG_EXPECTED_REPLY, 32'(psrp_pkg::MODE_QUERY));
    for (i = 0; i < 7; i++) send_byte(8'hFF, i == 0);
    send_byte(8'h07, 1'b0);
    // query reply cut short by a switch to ack mode: the next byte is already
    // past the ack length, so it closes the reply (first byte 0x10, unrecognised)
    send_byte(8'h10, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    settle_block();
    write_reg(psrp_pkg::CFG_EXPECTED_REPLY, 32'(psrp_pkg::MODE_ACK));
    send_byte(8'h40, 1'b0);

    // ---- random part ----
    // Phases 0..3 stay in auto mode and walk the header through its reset value
    // and both extremes; phase 3 sends nine all-ones frames back to back, with
    // frame_start only on the first byte so the running sum wraps at 16 bits. Later
    // phases pick a mode and sometimes a header, then send a mix of good, corrupted,
    // truncated and noise replies; some phases stop mid-reply so the next register
    // write lands inside a reply.
    while (bytes_sent < ITEM_TARGET) begin
      settle_block();
      calm <= (phase >= 6 && phase < 12);
      if (phase == 0) begin
        write_reg(psrp_pkg::CFG_EXPECTED_REPLY,
                  ($urandom() & ~32'h3) | 32'(psrp_pkg::MODE_AUTO));
      end else if (phase >= 4 && $urandom_range(99) < 85) begin
        m = 2'($urandom_range(3));
        write_reg(psrp_pkg::CFG_EXPECTED_REPLY, ($urandom() & ~32'h3) | 32'(m));
      end
      if (phase == 1) begin
        write_reg(psrp_pkg::CFG_AUTO_HEADER, 32'h0000_0000);
      end else if (phase == 2) begin
        write_reg(psrp_pkg::CFG_AUTO_HEADER, psrp_pkg::HEADER_RESET);
      end else if (phase == 3) begin
        write_reg(psrp_pkg::CFG_AUTO_HEADER, 32'hFFFF_FFFF);
      end else if (phase > 3 && $urandom_range(99) < 30) begin
        case ($urandom_range(3))
          0:       hdr = 32'h0000_0000;
          1:       hdr = 32'hFFFF_FFFF;
          default: hdr = $urandom();
        endcase
        write_reg(psrp_pkg::CFG_AUTO_HEADER, hdr);
      end

      if (phase == 3) begin
        for (i = 0; i < 9 * psrp_pkg::AUTO_FRAME_BYTES; i++) send_byte(8'hFF, i == 0);
      end else begin
        nreplies = (cur_mode == psrp_pkg::MODE_AUTO) ? $urandom_range(3, 1)
                                                     : $urandom_range(8, 2);
        repeat (nreplies) begin
          kind = $urandom_range(99);
          if (kind < 70) begin
            // well-formed, occasionally relying on the boundary instead of frame_start
            n = build_frame();
            send_frame(n, $urandom_range(9) != 0);
          end else if (kind < 82) begin
            // one flipped bit anywhere in the reply
            n = build_frame();
            p = $urandom_range(n - 1);
            i = $urandom_range(7);
            frame_buf[p][i] = ~frame_buf[p][i];
            send_frame(n, 1'b1);
          end else if (kind < 92) begin
            // truncated; a next reply that opens with frame_start restarts the count
            n = build_frame();
            send_frame($urandom_range(n - 1, 1), 1'b1);
          end else begin
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom()), $urandom_range(9) == 0);
          end
        end
        if ($urandom_range(99) < 20) begin
          n = build_frame();
          send_frame($urandom_range(n - 1, 1), 1'b1);
        end
      end
      phase++;
    end

    // ---- drain and verdict ----
    settle_block();
    repeat (8) @(posedge clk);
    $display("Sent %0d sensor bytes over %0d register phases in all four reply modes;",
             bytes_sent, phase);
    $display("compared %0d reply results field by field.", replies_checked);
    if (mismatches == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/psrp_pkg.sv
rtl/psrp_step.sv
rtl/particle_sensor_reply_parser.sv
rtl/psrp_checker.sv
tb/reply_parser_checker.sv
tb/testbench.sv
